// ===== design/multiscale_box_occupancy_counter_defines.svh =====
// ----------------------------------------------------------------------------
// Multiscale box occupancy counter: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MULTISCALE_BOX_OCCUPANCY_COUNTER_DEFINES_SVH
`define MULTISCALE_BOX_OCCUPANCY_COUNTER_DEFINES_SVH

// Same-cycle implication
`define MBOC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MBOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mboc_pkg.sv =====
// ----------------------------------------------------------------------------
// mboc_pkg
// Constants, codes and helpers of the multiscale box occupancy counter.
// ----------------------------------------------------------------------------
package mboc_pkg;

  // Grid and counter sizing
  localparam int unsigned GRID_SIDE  = 96;
  localparam int unsigned COUNT_BITS = 20;
  localparam int unsigned OUT_BITS   = 20;
  localparam int unsigned NUM_SCALES = 8;

  // Pad coordinate after the 1-based offset is removed
  localparam int unsigned COORD_BITS = $clog2(GRID_SIDE);

  // Cell sizes and the derived map geometry
  localparam int unsigned SCALE_SIZE [NUM_SCALES] = '{1, 2, 3, 4, 6, 8, 12, 16};
  localparam int unsigned SCALE_SIDE [NUM_SCALES] = '{
    (GRID_SIDE + 0) / 1,  (GRID_SIDE + 1) / 2,  (GRID_SIDE + 2) / 3,
    (GRID_SIDE + 3) / 4,  (GRID_SIDE + 5) / 6,  (GRID_SIDE + 7) / 8,
    (GRID_SIDE + 11) / 12, (GRID_SIDE + 15) / 16
  };
  localparam int unsigned SCALE_DEPTH [NUM_SCALES] = '{
    SCALE_SIDE[0] * SCALE_SIDE[0], SCALE_SIDE[1] * SCALE_SIDE[1],
    SCALE_SIDE[2] * SCALE_SIDE[2], SCALE_SIDE[3] * SCALE_SIDE[3],
    SCALE_SIDE[4] * SCALE_SIDE[4], SCALE_SIDE[5] * SCALE_SIDE[5],
    SCALE_SIDE[6] * SCALE_SIDE[6], SCALE_SIDE[7] * SCALE_SIDE[7]
  };
  localparam int unsigned SWEEP_BITS = $clog2(SCALE_DEPTH[0]);

  // Plane generation tag kept in each map entry; zero means never marked
  localparam int unsigned EPOCH_BITS = 8;

  // x / 3 as (x * 43) >> 7, exact for x below 128
  localparam int unsigned DIV3_MUL   = 43;
  localparam int unsigned DIV3_SHIFT = 7;
  localparam int unsigned PROD_BITS  = COORD_BITS + 6;

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_HIT    = 2'd0,
    FUNC_PLANE  = 2'd1,
    FUNC_SHOWER = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Threshold select values
  localparam logic [1:0] THR_CODE2 = 2'd0;
  localparam logic [1:0] THR_CODE1 = 2'd1;
  localparam logic [1:0] THR_CODE3 = 2'd2;

  // Amplitude codes
  localparam logic [1:0] AMP_CODE0 = 2'd0;
  localparam logic [1:0] AMP_CODE1 = 2'd1;
  localparam logic [1:0] AMP_CODE2 = 2'd2;

  // Amplitude filter: code 0 always passes, the others on their select value
  function automatic logic amp_kept(input logic [1:0] code, input logic [1:0] sel);
    logic keep;
    unique case (code)
      AMP_CODE0: keep = 1'b1;
      AMP_CODE1: keep = (sel == THR_CODE1);
      AMP_CODE2: keep = (sel == THR_CODE2);
      default:   keep = (sel == THR_CODE3);
    endcase
    return keep;
  endfunction

  // Divide by three with a reciprocal multiply
  function automatic logic [COORD_BITS-1:0] div3(input logic [COORD_BITS-1:0] x);
    logic [PROD_BITS-1:0] prod;
    prod = PROD_BITS'(x) * PROD_BITS'(DIV3_MUL);
    return COORD_BITS'(prod >> DIV3_SHIFT);
  endfunction

  // Cell coordinate of a 0-based pad coordinate at one scale
  function automatic logic [COORD_BITS-1:0] cell_coord(input int unsigned scale,
                                                       input logic [COORD_BITS-1:0] x);
    logic [COORD_BITS-1:0] q;
    unique case (scale)
      0:       q = x;
      1:       q = x >> 1;
      2:       q = div3(x);
      3:       q = x >> 2;
      4:       q = div3(x >> 1);
      5:       q = x >> 3;
      6:       q = div3(x >> 2);
      default: q = x >> 4;
    endcase
    return q;
  endfunction

endpackage

// ===== design/mboc_ram.sv =====
// ----------------------------------------------------------------------------
// mboc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mboc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/multiscale_box_occupancy_counter.sv =====
// ----------------------------------------------------------------------------
// multiscale_box_occupancy_counter
// Box counting over eight cell scales for a shower's fractal dimension.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/in_* and are taken at an edge where busy is low.
//   in_func selects a pad hit, end of plane or end of shower; code 3 is ignored.
//   threshold_select is written on cfg_valid/cfg_data; cfg_ready is always high.
//   Each map is a RAM holding a plane tag per cell. A request reads all eight maps
//   at its accept edge and compares, counts and writes back in the cycle after,
//   so one request is taken per cycle unless busy; a hit right after a hit is forwarded.
//   End of plane and end of shower advance the tag instead of clearing the maps.
//   Every 255th of them wraps the tag and runs a clearing pass over the maps
//   (one entry of every map per cycle); busy is high for the write-back cycle
//   of the wrapping request and through the pass, and low otherwise.
//   An end of shower puts the eight counts on out_count_* with out_valid high for
//   one cycle; the report passes through stage two and the report register.
//   The receiver cannot stall.
//   Reset: threshold_select and the counters go to zero and the clearing pass
//   runs, so busy stays high after rst_n is released until that pass ends.
// ----------------------------------------------------------------------------
`include "multiscale_box_occupancy_counter_defines.svh"

module multiscale_box_occupancy_counter (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_pad_col,
  input  logic [7:0]  in_pad_row,
  input  logic [1:0]  in_amp_code,
  // result channel
  output logic        out_valid,
  output logic [19:0] out_count_s1,
  output logic [19:0] out_count_s2,
  output logic [19:0] out_count_s3,
  output logic [19:0] out_count_s4,
  output logic [19:0] out_count_s6,
  output logic [19:0] out_count_s8,
  output logic [19:0] out_count_s12,
  output logic [19:0] out_count_s16,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  localparam int unsigned NS = mboc_pkg::NUM_SCALES;
  localparam int unsigned CB = mboc_pkg::COUNT_BITS;
  localparam int unsigned OB = mboc_pkg::OUT_BITS;
  localparam int unsigned CW = mboc_pkg::COORD_BITS;
  localparam int unsigned EB = mboc_pkg::EPOCH_BITS;
  localparam int unsigned SB = mboc_pkg::SWEEP_BITS;

  localparam logic [EB-1:0] EPOCH_FIRST = EB'(1);
  localparam logic [EB-1:0] EPOCH_LAST  = '1;
  localparam logic [CB-1:0] COUNT_MAX   = '1;
  localparam logic [SB-1:0] SWEEP_LAST  = SB'(mboc_pkg::SCALE_DEPTH[0] - 1);
  localparam logic [7:0]    GRID_MAX    = 8'(mboc_pkg::GRID_SIDE);

  // Control state
  logic [1:0]             threshold_r;
  logic                   s2_valid_r;
  mboc_pkg::func_t        s2_func_r;
  logic                   s2_keep_r;
  logic                   prev_wr_r;
  logic [EB-1:0]          epoch_r, epoch_nxt;
  logic                   sweep_r, sweep_nxt;
  logic [SB-1:0]          sweep_cnt_r, sweep_cnt_nxt;
  logic [CB-1:0]          cnt_r [NS];
  logic [CB-1:0]          cnt_nxt [NS];
  logic                   out_valid_r, out_valid_nxt;
  logic [OB-1:0]          out_count_r [NS];

  logic                   accept;
  logic                   in_keep;
  logic [CW-1:0]          col0, row0;
  logic                   s2_hit_we;
  logic                   s2_clear;
  logic                   s2_shower;
  logic                   wrap_pending;
  logic [NS-1:0]          inc;
  logic                   cnt_zero;

  // Request handshake
  assign wrap_pending = s2_clear && (epoch_r == EPOCH_LAST);
  assign busy         = sweep_r || wrap_pending;
  assign accept       = start && !busy;
  assign cfg_ready    = 1'b1;

  // Hit filter and 0-based pad coordinates
  assign in_keep = mboc_pkg::amp_kept(in_amp_code, threshold_r) &&
                   (in_pad_col != 8'd0) && (in_pad_col <= GRID_MAX) &&
                   (in_pad_row != 8'd0) && (in_pad_row <= GRID_MAX);
  assign col0 = CW'(in_pad_col - 8'd1);
  assign row0 = CW'(in_pad_row - 8'd1);

  // Stage two decode
  assign s2_hit_we = s2_valid_r && (s2_func_r == mboc_pkg::FUNC_HIT) && s2_keep_r;
  assign s2_clear  = s2_valid_r && ((s2_func_r == mboc_pkg::FUNC_PLANE) ||
                                    (s2_func_r == mboc_pkg::FUNC_SHOWER));
  assign s2_shower = s2_valid_r && (s2_func_r == mboc_pkg::FUNC_SHOWER);

  // Per-scale map: address, tag RAM, hit check with forwarding
  for (genvar k = 0; k < NS; k++) begin : g_scale
    localparam int unsigned DEPTH = mboc_pkg::SCALE_DEPTH[k];
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [CW-1:0] q_col, q_row;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] s2_addr_r;
    logic [AW-1:0] prev_addr_r;
    logic [EB-1:0] tag;
    logic          we;
    logic [AW-1:0] waddr;
    logic [EB-1:0] wdata;
    logic          already;

    assign q_col   = mboc_pkg::cell_coord(k, col0);
    assign q_row   = mboc_pkg::cell_coord(k, row0);
    assign rd_addr = AW'(q_col) * AW'(mboc_pkg::SCALE_SIDE[k]) + AW'(q_row);

    // Sweep writes zero tags; otherwise a kept hit stamps the current plane
    assign we    = sweep_r ? (sweep_cnt_r < SB'(DEPTH)) : s2_hit_we;
    assign waddr = sweep_r ? AW'(sweep_cnt_r) : s2_addr_r;
    assign wdata = sweep_r ? '0 : epoch_r;

    mboc_ram #(
      .WIDTH (EB),
      .DEPTH (DEPTH)
    ) u_map (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (rd_addr),
      .rdata (tag)
    );

    // Cell already set this plane, or written by the hit just before
    assign already = (tag == epoch_r) || (prev_wr_r && (prev_addr_r == s2_addr_r));
    assign inc[k]  = s2_hit_we && !already;

    always_ff @(posedge clk) begin
      if (accept) begin
        s2_addr_r <= rd_addr;
      end
      prev_addr_r <= s2_addr_r;
    end
  end

  // Counters, plane tag and clearing pass
  always_comb begin
    epoch_nxt     = epoch_r;
    sweep_nxt     = sweep_r;
    sweep_cnt_nxt = sweep_cnt_r;
    out_valid_nxt = s2_shower;
    for (int k = 0; k < NS; k++) begin
      cnt_nxt[k] = cnt_r[k];
      if (s2_shower) begin
        cnt_nxt[k] = '0;
      end else if (inc[k] && (cnt_r[k] != COUNT_MAX)) begin
        cnt_nxt[k] = cnt_r[k] + CB'(1);
      end
    end
    if (sweep_r) begin
      sweep_cnt_nxt = sweep_cnt_r + SB'(1);
      if (sweep_cnt_r == SWEEP_LAST) begin
        sweep_nxt = 1'b0;
      end
    end else if (s2_clear) begin
      if (epoch_r == EPOCH_LAST) begin
        epoch_nxt     = EPOCH_FIRST;
        sweep_nxt     = 1'b1;
        sweep_cnt_nxt = '0;
      end else begin
        epoch_nxt = epoch_r + EB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= mboc_pkg::THR_CODE2;
      s2_valid_r  <= 1'b0;
      prev_wr_r   <= 1'b0;
      epoch_r     <= EPOCH_FIRST;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold_r <= cfg_data;
      end
      s2_valid_r  <= accept;
      prev_wr_r   <= s2_hit_we;
      epoch_r     <= epoch_nxt;
      sweep_r     <= sweep_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < NS; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  // Stage two payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s2_func_r <= mboc_pkg::func_t'(in_func);
      s2_keep_r <= in_keep;
    end
  end

  // Report register
  always_ff @(posedge clk) begin
    if (s2_shower) begin
      for (int k = 0; k < NS; k++) begin
        out_count_r[k] <= OB'(cnt_r[k]);
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_count_s1  = out_count_r[0];
  assign out_count_s2  = out_count_r[1];
  assign out_count_s3  = out_count_r[2];
  assign out_count_s4  = out_count_r[3];
  assign out_count_s6  = out_count_r[4];
  assign out_count_s8  = out_count_r[5];
  assign out_count_s12 = out_count_r[6];
  assign out_count_s16 = out_count_r[7];

  // All counters at zero
  always_comb begin
    cnt_zero = 1'b1;
    for (int k = 0; k < NS; k++) begin
      if (cnt_r[k] != '0) begin
        cnt_zero = 1'b0;
      end
    end
  end

  // Checks
  `MBOC_ASSERT_NEXT(a_report_follows_shower, s2_shower, out_valid_r, "end of shower without report")
  `MBOC_ASSERT_IMPLIES(a_report_has_cause, out_valid_r, $past(s2_shower), "report without end of shower")
  `MBOC_ASSERT_IMPLIES(a_counts_clear_on_report, out_valid_r, cnt_zero, "counters not cleared on report")
  `MBOC_ASSERT_IMPLIES(a_no_work_in_sweep, sweep_r, !s2_valid_r, "request in flight during clearing pass")
  `MBOC_ASSERT_IMPLIES(a_epoch_nonzero, 1'b1, epoch_r != '0, "plane tag hit the never-marked value")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pad hits, plane ends and shower ends into the box occupancy counter
// under each amplitude threshold setting, and predicts the eight per-scale
// occupancy counts of every shower report. Reports are compared field by field.
// ----------------------------------------------------------------------------
module testbench;

  // Codes the package leaves unnamed
  localparam logic [1:0] AMP_CODE3 = 2'd3;
  localparam logic [1:0] THR_ZERO_ONLY = 2'd3;

  localparam int unsigned CELL_PADS [mboc_pkg::NUM_SCALES] = '{1, 2, 3, 4, 6, 8, 12, 16};
  localparam int unsigned CELL_SLOTS = mboc_pkg::GRID_SIDE * mboc_pkg::GRID_SIDE;
  localparam longint unsigned COUNT_MAX = (64'd1 << mboc_pkg::COUNT_BITS) - 64'd1;

  typedef logic [mboc_pkg::NUM_SCALES-1:0][mboc_pkg::OUT_BITS-1:0] report_t;

  // Occupancy predictor and report checker
  class occupancy_scoreboard;
    logic [1:0] thr;
    int unsigned plane_tag;
    int unsigned cell_tag [mboc_pkg::NUM_SCALES][CELL_SLOTS];
    longint unsigned tally [mboc_pkg::NUM_SCALES];
    report_t reports_due [$];
    string field_name [mboc_pkg::NUM_SCALES];
    int errors;

    function new();
      thr = mboc_pkg::THR_CODE2;
      plane_tag = 1;
      foreach (cell_tag[k, i]) cell_tag[k][i] = 0;
      foreach (tally[k]) tally[k] = 0;
      field_name = '{"count_s1", "count_s2", "count_s3", "count_s4",
                     "count_s6", "count_s8", "count_s12", "count_s16"};
      errors = 0;
    endfunction

    function bit amp_passes(logic [1:0] code);
      case (code)
        mboc_pkg::AMP_CODE0: return 1'b1;
        mboc_pkg::AMP_CODE1: return thr == mboc_pkg::THR_CODE1;
        mboc_pkg::AMP_CODE2: return thr == mboc_pkg::THR_CODE2;
        default:             return thr == mboc_pkg::THR_CODE3;
      endcase
    endfunction

    // Update the predicted state for one accepted request
    function void note_request(logic [1:0] f, logic [7:0] col, logic [7:0] row,
                               logic [1:0] amp);
      int unsigned c, r, pads, side, slot;
      report_t rep;
      case (f)
        mboc_pkg::FUNC_HIT: begin
          if (amp_passes(amp) && col >= 1 && col <= mboc_pkg::GRID_SIDE &&
              row >= 1 && row <= mboc_pkg::GRID_SIDE) begin
            c = col - 1;
            r = row - 1;
            for (int k = 0; k < mboc_pkg::NUM_SCALES; k++) begin
              pads = CELL_PADS[k];
              side = (mboc_pkg::GRID_SIDE + pads - 1) / pads;
              slot = (c / pads) * side + r / pads;
              // first mark of a cell in this plane
              if (cell_tag[k][slot] != plane_tag) begin
                cell_tag[k][slot] = plane_tag;
                if (tally[k] < COUNT_MAX) tally[k]++;
              end
            end
          end
        end
        mboc_pkg::FUNC_PLANE: plane_tag++;
        mboc_pkg::FUNC_SHOWER: begin
          for (int k = 0; k < mboc_pkg::NUM_SCALES; k++) begin
            rep[k] = mboc_pkg::OUT_BITS'(tally[k]);
            tally[k] = 0;
          end
          reports_due = {reports_due, rep};
          plane_tag++;
        end
        default: ;
      endcase
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (reports_due.size() == 0) begin
        $error("report with no shower end pending");
        errors++;
        return;
      end
      want = reports_due.pop_front();
      for (int k = 0; k < mboc_pkg::NUM_SCALES; k++) begin
        if (got[k] !== want[k]) begin
          $error("%s: expected %0d, actual %0d", field_name[k], want[k], got[k]);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [7:0]  in_pad_col;
  logic [7:0]  in_pad_row;
  logic [1:0]  in_amp_code;
  logic        out_valid;
  logic [19:0] out_count_s1, out_count_s2, out_count_s3, out_count_s4;
  logic [19:0] out_count_s6, out_count_s8, out_count_s12, out_count_s16;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;

  occupancy_scoreboard sb;
  int gap_pct;
  int requests_sent;

  multiscale_box_occupancy_counter dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_func(in_func), .in_pad_col(in_pad_col), .in_pad_row(in_pad_row),
    .in_amp_code(in_amp_code),
    .out_valid(out_valid),
    .out_count_s1(out_count_s1), .out_count_s2(out_count_s2),
    .out_count_s3(out_count_s3), .out_count_s4(out_count_s4),
    .out_count_s6(out_count_s6), .out_count_s8(out_count_s8),
    .out_count_s12(out_count_s12), .out_count_s16(out_count_s16),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Report monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_report({out_count_s16, out_count_s12, out_count_s8, out_count_s6,
                       out_count_s4, out_count_s3, out_count_s2, out_count_s1});
  end

  // One request, with a random idle gap ahead of it
  task automatic send(logic [1:0] f, logic [7:0] col, logic [7:0] row,
                      logic [1:0] amp);
    int idle;
    idle = 0;
    if ($urandom_range(99) < gap_pct) idle = $urandom_range(1, 2);
    @(negedge clk);
    if (idle != 0) begin
      start = 1'b0;
      repeat (idle) @(negedge clk);
    end
    start = 1'b1;
    in_func = f;
    in_pad_col = col;
    in_pad_row = row;
    in_amp_code = amp;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(f, col, row, amp);
    if (f != mboc_pkg::FUNC_NONE) requests_sent++;
  endtask

  // Threshold write, only once the block has settled
  task automatic write_threshold(logic [1:0] v);
    @(negedge clk);
    start = 1'b0;
    while (sb.reports_due.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.thr = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hit near a cluster center; a few land anywhere, off grid included
  task automatic random_hit(int cc, int cr, int rad);
    logic [7:0] col, row;
    if ($urandom_range(99) < 6) begin
      col = 8'($urandom);
      row = 8'($urandom);
    end else begin
      col = 8'(cc + int'($urandom_range(0, 2 * rad)) - rad);
      row = 8'(cr + int'($urandom_range(0, 2 * rad)) - rad);
    end
    send(mboc_pkg::FUNC_HIT, col, row, 2'($urandom));
  endtask

  // Well-formed shower: planes of clustered hits, then the shower end
  task automatic random_shower();
    int planes, hits, cc, cr, rad;
    planes = $urandom_range(1, 4);
    repeat (planes) begin
      hits = $urandom_range(1, 8);
      cc = $urandom_range(1, mboc_pkg::GRID_SIDE);
      cr = $urandom_range(1, mboc_pkg::GRID_SIDE);
      rad = ($urandom_range(9) == 0) ? 48 : $urandom_range(0, 6);
      repeat (hits) begin
        random_hit(cc, cr, rad);
        if ($urandom_range(99) < 4)
          send(mboc_pkg::FUNC_NONE, 8'($urandom), 8'($urandom), 2'($urandom));
      end
      // sometimes no plane end follows, so the plane runs on into the next one or ends with the shower
      if ($urandom_range(3) != 0)
        send(mboc_pkg::FUNC_PLANE, 8'($urandom), 8'($urandom), 2'($urandom));
    end
    send(mboc_pkg::FUNC_SHOWER, 8'($urandom), 8'($urandom), 2'($urandom));
  endtask

  // Random phase at one threshold setting
  task automatic run_phase(int quota, bit burst);
    int target;
    target = requests_sent + quota;
    // plane and shower ends with a hit now and then, pushing the plane tag toward a wrap
    if (burst) begin
      repeat (60) begin
        if ($urandom_range(4) == 0)
          random_hit($urandom_range(1, mboc_pkg::GRID_SIDE),
                     $urandom_range(1, mboc_pkg::GRID_SIDE), 2);
        else
          send($urandom_range(1) ? mboc_pkg::FUNC_PLANE : mboc_pkg::FUNC_SHOWER,
               8'($urandom), 8'($urandom), 2'($urandom));
      end
    end
    while (requests_sent < target) begin
      if ($urandom_range(99) < 85)
        random_shower();
      else
        send(2'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
    end
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [1:0] thr_seq [8];
    thr_seq = '{THR_ZERO_ONLY, mboc_pkg::THR_CODE1, mboc_pkg::THR_CODE3,
                mboc_pkg::THR_CODE2, THR_ZERO_ONLY, mboc_pkg::THR_CODE3,
                mboc_pkg::THR_CODE1, mboc_pkg::THR_CODE2};
    sb = new();
    gap_pct = 20;
    requests_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = mboc_pkg::FUNC_NONE;
    in_pad_col = '0;
    in_pad_row = '0;
    in_amp_code = mboc_pkg::AMP_CODE0;
    cfg_valid = 1'b0;
    cfg_data = mboc_pkg::THR_CODE2;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: grid corners, repeated cells, drops, ignored code, plane reuse
    send(mboc_pkg::FUNC_HIT, 8'd1, 8'd1, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd96, 8'd96, mboc_pkg::AMP_CODE2);
    send(mboc_pkg::FUNC_HIT, 8'd1, 8'd96, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd96, 8'd1, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd1, 8'd1, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd2, 8'd2, mboc_pkg::AMP_CODE2);
    send(mboc_pkg::FUNC_HIT, 8'd0, 8'd5, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd97, 8'd5, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd5, 8'd0, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd5, 8'd97, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd255, 8'd255, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd128, 8'd200, mboc_pkg::AMP_CODE2);
    send(mboc_pkg::FUNC_HIT, 8'd40, 8'd40, mboc_pkg::AMP_CODE1);
    send(mboc_pkg::FUNC_HIT, 8'd41, 8'd41, AMP_CODE3);
    send(mboc_pkg::FUNC_NONE, 8'd50, 8'd50, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_PLANE, 8'd0, 8'd0, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd1, 8'd1, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd48, 8'd49, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_SHOWER, 8'd255, 8'd255, AMP_CODE3);
    send(mboc_pkg::FUNC_SHOWER, 8'd0, 8'd0, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_HIT, 8'd48, 8'd48, mboc_pkg::AMP_CODE0);
    send(mboc_pkg::FUNC_NONE, 8'd255, 8'd255, AMP_CODE3);
    send(mboc_pkg::FUNC_SHOWER, 8'd0, 8'd0, mboc_pkg::AMP_CODE0);

    // Random phases over all threshold settings; one without idle gaps
    for (int p = 0; p < 8; p++) begin
      write_threshold(thr_seq[p]);
      gap_pct = (p == 2) ? 0 : 20;
      run_phase(160, p == 3);
    end

    // Drain
    @(negedge clk);
    start = 1'b0;
    while (sb.reports_due.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
